// ===== design/fresnel_reflectance_unit_macros.svh =====
// Assertion macros for the Fresnel reflectance unit checker.
// No dependencies; included by the checker file.
`ifndef FRESNEL_REFLECTANCE_UNIT_MACROS_SVH
`define FRESNEL_REFLECTANCE_UNIT_MACROS_SVH

// Property that must hold in the same cycle, outside reset.
`define FRU_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fresnel unit check failed");

// Property that must hold in the cycle after the antecedent.
`define FRU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fresnel unit check failed");

`endif

// ===== design/frp_pkg.sv =====
// Widths and constants shared by the Fresnel reflectance unit and its checker.
// No dependencies.
package frp_pkg;
   localparam int NW    = 14;           // index, Q2.12
   localparam int CW    = 17;           // cosine and results, Q1.16
   localparam int NNW   = 2 * NW;       // n^2
   localparam int DW    = 36;           // radicand n^2 - s^2 in Q32
   localparam int RTW   = DW / 2;       // raw square root bits
   localparam int REMW  = RTW + 2;      // square root remainder
   localparam int WW    = RTW + 1;      // rounded root
   localparam int PW    = 21;           // n^2 c in Q16
   localparam int BW    = 21;           // ratio operands
   localparam int B2W   = 2 * BW;       // squared operands
   localparam int FRAC  = 20;           // fraction bits of squared ratio
   localparam int QW    = FRAC + 1;     // quotient bits
   localparam int NUMW  = B2W + FRAC + 1;
   localparam int SQ_STAGES  = RTW;
   localparam int DIV_STAGES = QW;
   localparam logic [CW-1:0] ONE_Q16 = CW'(65536);
   localparam logic [QW-1:0] ONE_Q20 = QW'(1 << FRAC);
endpackage

// ===== design/fresnel_reflectance_unit.sv =====
// Fully pipelined unpolarized Fresnel reflectance unit.
// Depends on frp_pkg.
//
// Usage: present rel_index (Q2.12) and cos_incidence (Q1.16) on the req_
// channel; one result beat with reflectance, transmittance and the total
// reflection flag comes back on the rsp_ channel for every request beat,
// in order. Cosines above one are clamped to one.
// Throughput: one beat per cycle while the receiver takes results. Depth:
// 46 register stages from request to result. The stages are the 18 steps
// of the digit-by-digit square root, the 21 steps of the two restoring
// dividers, and seven stages of multiply, compare, operand setup and
// output logic.
// All stages advance together; when the receiver stalls with a result
// waiting, the whole pipeline holds, req_ready drops, and nothing is lost
// or repeated. Reset clears every valid bit, so the pipeline comes up
// empty and ready for a beat in the first cycle after reset.
module fresnel_reflectance_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [frp_pkg::NW-1:0]  req_rel_index,
   input  logic [frp_pkg::CW-1:0]  req_cos_incidence,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [frp_pkg::CW-1:0]  rsp_reflectance,
   output logic [frp_pkg::CW-1:0]  rsp_transmittance,
   output logic                    rsp_total_reflection
);
   import frp_pkg::*;

   logic adv;

   // Input stage.
   logic            s0_vld_ff;
   logic [NW-1:0]   s0_n_ff;
   logic [CW-1:0]   s0_c_ff;
   logic [CW-1:0]   s0_c_in;

   // Product stage.
   logic            s1_vld_ff;
   logic [NNW-1:0]  s1_nn_ff;
   logic [2*CW-1:0] s1_cc_ff;
   logic [CW-1:0]   s1_c_ff;

   // Compare stage outputs.
   logic [32:0]     s2_s2;
   logic [DW-1:0]   s2_m;
   logic [NNW+CW:0] s2_psum;

   // Square root pipeline.
   logic            sq_vld_ff  [0:SQ_STAGES];
   logic [REMW-1:0] sq_rem_ff  [0:SQ_STAGES];
   logic [RTW-1:0]  sq_root_ff [0:SQ_STAGES];
   logic [DW-1:0]   sq_d_ff    [0:SQ_STAGES];
   logic [CW-1:0]   sq_c_ff    [0:SQ_STAGES];
   logic [PW-1:0]   sq_p_ff    [0:SQ_STAGES];
   logic            sq_tir_ff  [0:SQ_STAGES];
   logic [REMW-1:0] sq_rem_in  [0:SQ_STAGES-1];
   logic [RTW-1:0]  sq_root_in [0:SQ_STAGES-1];

   // Ratio operand stage.
   logic [WW-1:0]   w_in;
   logic            ab_vld_ff;
   logic            ab_tir_ff;
   logic [BW-1:0]   as_ff, bs_ff, ap_ff, bp_ff;

   // Square stage.
   logic            sqr_vld_ff;
   logic            sqr_tir_ff;
   logic [B2W-1:0]  as2_ff, bs2_ff, ap2_ff, bp2_ff;
   logic [NUMW-1:0] nums_in, nump_in;

   // Divider pipeline, s and p ratios side by side.
   logic            dv_vld_ff   [0:DIV_STAGES];
   logic            dv_tir_ff   [0:DIV_STAGES];
   logic            dv_zs_ff    [0:DIV_STAGES];
   logic            dv_zp_ff    [0:DIV_STAGES];
   logic [B2W-1:0]  dv_rs_ff    [0:DIV_STAGES];
   logic [B2W-1:0]  dv_rp_ff    [0:DIV_STAGES];
   logic [QW-1:0]   dv_ls_ff    [0:DIV_STAGES];
   logic [QW-1:0]   dv_lp_ff    [0:DIV_STAGES];
   logic [B2W-1:0]  dv_bs_ff    [0:DIV_STAGES];
   logic [B2W-1:0]  dv_bp_ff    [0:DIV_STAGES];
   logic [QW-1:0]   dv_qs_ff    [0:DIV_STAGES];
   logic [QW-1:0]   dv_qp_ff    [0:DIV_STAGES];
   logic [B2W-1:0]  dv_rs_in    [0:DIV_STAGES-1];
   logic [B2W-1:0]  dv_rp_in    [0:DIV_STAGES-1];
   logic [QW-1:0]   dv_qs_in    [0:DIV_STAGES-1];
   logic [QW-1:0]   dv_qp_in    [0:DIV_STAGES-1];

   // Output stage.
   logic [QW-1:0]   ts_in, tp_in;
   logic [QW+1:0]   rsum_in;
   logic [CW-1:0]   refl_in;
   logic            rsp_valid_ff;
   logic [CW-1:0]   rsp_refl_ff, rsp_trans_ff;
   logic            rsp_tir_ff;

   // The whole pipeline moves whenever the output register can take a beat.
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   assign s0_c_in = (req_cos_incidence > ONE_Q16) ? ONE_Q16 : req_cos_incidence;

   // Compare logic: s^2 = 1 - c^2 against n^2, and n^2 c with rounding.
   always_comb begin
      s2_s2   = 33'h1_0000_0000 - s1_cc_ff[32:0];
      s2_m    = {s1_nn_ff, 8'b0};
      s2_psum = (NNW+CW+1)'(s1_nn_ff * s1_c_ff) + (NNW+CW+1)'(1 << 23);
   end

   // One restoring square root step per stage, two radicand bits each.
   always_comb begin
      for (int k = 0; k < SQ_STAGES; k++) begin
         logic [REMW:0] rsh;
         logic [REMW:0] trial;
         rsh   = {sq_rem_ff[k][REMW-2:0], sq_d_ff[k][DW-1:DW-2]};
         trial = {1'b0, sq_root_ff[k], 2'b01};
         if (rsh >= trial) begin
            sq_rem_in[k]  = REMW'(rsh - trial);
            sq_root_in[k] = {sq_root_ff[k][RTW-2:0], 1'b1};
         end else begin
            sq_rem_in[k]  = REMW'(rsh);
            sq_root_in[k] = {sq_root_ff[k][RTW-2:0], 1'b0};
         end
      end
   end

   // Round the root to nearest.
   assign w_in = {1'b0, sq_root_ff[SQ_STAGES]} +
                 WW'(sq_rem_ff[SQ_STAGES] > {2'b0, sq_root_ff[SQ_STAGES]});

   // Dividends: a^2 scaled by 2^20 plus half the divisor for rounding.
   assign nums_in = {1'b0, as2_ff, {FRAC{1'b0}}} + NUMW'(bs2_ff >> 1);
   assign nump_in = {1'b0, ap2_ff, {FRAC{1'b0}}} + NUMW'(bp2_ff >> 1);

   // One quotient bit per stage for each ratio.
   always_comb begin
      for (int k = 0; k < DIV_STAGES; k++) begin
         logic [B2W:0] shs;
         logic [B2W:0] shp;
         shs = {dv_rs_ff[k], dv_ls_ff[k][QW-1]};
         shp = {dv_rp_ff[k], dv_lp_ff[k][QW-1]};
         if (shs >= {1'b0, dv_bs_ff[k]}) begin
            dv_rs_in[k] = B2W'(shs - {1'b0, dv_bs_ff[k]});
            dv_qs_in[k] = {dv_qs_ff[k][QW-2:0], 1'b1};
         end else begin
            dv_rs_in[k] = B2W'(shs);
            dv_qs_in[k] = {dv_qs_ff[k][QW-2:0], 1'b0};
         end
         if (shp >= {1'b0, dv_bp_ff[k]}) begin
            dv_rp_in[k] = B2W'(shp - {1'b0, dv_bp_ff[k]});
            dv_qp_in[k] = {dv_qp_ff[k][QW-2:0], 1'b1};
         end else begin
            dv_rp_in[k] = B2W'(shp);
            dv_qp_in[k] = {dv_qp_ff[k][QW-2:0], 1'b0};
         end
      end
   end

   // Average of the squared ratios, with the zero-divisor case as one.
   always_comb begin
      ts_in   = dv_zs_ff[DIV_STAGES] ? ONE_Q20 : dv_qs_ff[DIV_STAGES];
      tp_in   = dv_zp_ff[DIV_STAGES] ? ONE_Q20 : dv_qp_ff[DIV_STAGES];
      rsum_in = {2'b0, ts_in} + {2'b0, tp_in} + (QW+2)'(16);
      if (rsum_in[QW+1:5] > {1'b0, ONE_Q16}) begin
         refl_in = ONE_Q16;
      end else begin
         refl_in = CW'(rsum_in[QW+1:5]);
      end
   end

   // Valid bits, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff    <= 1'b0;
         s1_vld_ff    <= 1'b0;
         ab_vld_ff    <= 1'b0;
         sqr_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k <= SQ_STAGES; k++) begin
            sq_vld_ff[k] <= 1'b0;
         end
         for (int k = 0; k <= DIV_STAGES; k++) begin
            dv_vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         s0_vld_ff    <= req_valid;
         s1_vld_ff    <= s0_vld_ff;
         sq_vld_ff[0] <= s1_vld_ff;
         for (int k = 0; k < SQ_STAGES; k++) begin
            sq_vld_ff[k+1] <= sq_vld_ff[k];
         end
         ab_vld_ff    <= sq_vld_ff[SQ_STAGES];
         sqr_vld_ff   <= ab_vld_ff;
         dv_vld_ff[0] <= sqr_vld_ff;
         for (int k = 0; k < DIV_STAGES; k++) begin
            dv_vld_ff[k+1] <= dv_vld_ff[k];
         end
         rsp_valid_ff <= dv_vld_ff[DIV_STAGES];
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (adv) begin
         s0_n_ff <= req_rel_index;
         s0_c_ff <= s0_c_in;

         s1_nn_ff <= NNW'(s0_n_ff * s0_n_ff);
         s1_cc_ff <= (2*CW)'(s0_c_ff * s0_c_ff);
         s1_c_ff  <= s0_c_ff;

         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
         sq_d_ff[0]    <= DW'(s2_m - {3'b0, s2_s2});
         sq_c_ff[0]    <= s1_c_ff;
         sq_p_ff[0]    <= s2_psum[24+PW-1:24];
         sq_tir_ff[0]  <= ({3'b0, s2_s2} > s2_m);
         for (int k = 0; k < SQ_STAGES; k++) begin
            sq_rem_ff[k+1]  <= sq_rem_in[k];
            sq_root_ff[k+1] <= sq_root_in[k];
            sq_d_ff[k+1]    <= {sq_d_ff[k][DW-3:0], 2'b00};
            sq_c_ff[k+1]    <= sq_c_ff[k];
            sq_p_ff[k+1]    <= sq_p_ff[k];
            sq_tir_ff[k+1]  <= sq_tir_ff[k];
         end

         ab_tir_ff <= sq_tir_ff[SQ_STAGES];
         as_ff <= ({2'b0, w_in} > {4'b0, sq_c_ff[SQ_STAGES]}) ?
                  BW'({2'b0, w_in} - {4'b0, sq_c_ff[SQ_STAGES]}) :
                  BW'({4'b0, sq_c_ff[SQ_STAGES]} - {2'b0, w_in});
         bs_ff <= {2'b0, w_in} + {4'b0, sq_c_ff[SQ_STAGES]};
         ap_ff <= ({2'b0, w_in} > sq_p_ff[SQ_STAGES]) ?
                  ({2'b0, w_in} - sq_p_ff[SQ_STAGES]) :
                  (sq_p_ff[SQ_STAGES] - {2'b0, w_in});
         bp_ff <= {2'b0, w_in} + sq_p_ff[SQ_STAGES];

         sqr_tir_ff <= ab_tir_ff;
         as2_ff <= B2W'(as_ff * as_ff);
         bs2_ff <= B2W'(bs_ff * bs_ff);
         ap2_ff <= B2W'(ap_ff * ap_ff);
         bp2_ff <= B2W'(bp_ff * bp_ff);

         dv_tir_ff[0] <= sqr_tir_ff;
         dv_zs_ff[0]  <= (bs2_ff == '0);
         dv_zp_ff[0]  <= (bp2_ff == '0);
         dv_rs_ff[0]  <= nums_in[NUMW-1:QW];
         dv_rp_ff[0]  <= nump_in[NUMW-1:QW];
         dv_ls_ff[0]  <= nums_in[QW-1:0];
         dv_lp_ff[0]  <= nump_in[QW-1:0];
         dv_bs_ff[0]  <= bs2_ff;
         dv_bp_ff[0]  <= bp2_ff;
         dv_qs_ff[0]  <= '0;
         dv_qp_ff[0]  <= '0;
         for (int k = 0; k < DIV_STAGES; k++) begin
            dv_tir_ff[k+1] <= dv_tir_ff[k];
            dv_zs_ff[k+1]  <= dv_zs_ff[k];
            dv_zp_ff[k+1]  <= dv_zp_ff[k];
            dv_rs_ff[k+1]  <= dv_rs_in[k];
            dv_rp_ff[k+1]  <= dv_rp_in[k];
            dv_ls_ff[k+1]  <= {dv_ls_ff[k][QW-2:0], 1'b0};
            dv_lp_ff[k+1]  <= {dv_lp_ff[k][QW-2:0], 1'b0};
            dv_bs_ff[k+1]  <= dv_bs_ff[k];
            dv_bp_ff[k+1]  <= dv_bp_ff[k];
            dv_qs_ff[k+1]  <= dv_qs_in[k];
            dv_qp_ff[k+1]  <= dv_qp_in[k];
         end

         rsp_tir_ff <= dv_tir_ff[DIV_STAGES];
         if (dv_tir_ff[DIV_STAGES]) begin
            rsp_refl_ff  <= ONE_Q16;
            rsp_trans_ff <= '0;
         end else begin
            rsp_refl_ff  <= refl_in;
            rsp_trans_ff <= ONE_Q16 - refl_in;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_reflectance      = rsp_refl_ff;
   assign rsp_transmittance    = rsp_trans_ff;
   assign rsp_total_reflection = rsp_tir_ff;
endmodule

// ===== design/fru_checker.sv =====
// Port-level checks for the Fresnel reflectance unit, bound to the top level.
// Depends on frp_pkg and fresnel_reflectance_unit_macros.svh.
`include "fresnel_reflectance_unit_macros.svh"

module fru_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic [frp_pkg::NW-1:0]  req_rel_index,
   input logic [frp_pkg::CW-1:0]  req_cos_incidence,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [frp_pkg::CW-1:0]  rsp_reflectance,
   input logic [frp_pkg::CW-1:0]  rsp_transmittance,
   input logic                    rsp_total_reflection
);
   import frp_pkg::*;

   // A stalled result beat holds its value.
   `FRU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_reflectance))
   // Reflectance and transmittance always add up to one.
   `FRU_ASSERT_NOW(a_sum_one, clock, reset, rsp_valid, (rsp_reflectance + rsp_transmittance) == ONE_Q16)
   // Total reflection reports full reflectance.
   `FRU_ASSERT_NOW(a_tir_full, clock, reset, rsp_valid && rsp_total_reflection, rsp_reflectance == ONE_Q16)
   // The request side is open whenever the output is free.
   `FRU_ASSERT_NOW(a_ready_free, clock, reset, !rsp_valid, req_ready)
endmodule

bind fresnel_reflectance_unit fru_checker u_fru_checker (.*);

// ===== dv/fresnel_reflectance_unit_tb.sv =====
// Testbench for the Fresnel reflectance unit: drives index/cosine beats, predicts
// reflectance, transmittance and the total reflection flag, and checks every result.
// Depends on frp_pkg and fresnel_reflectance_unit.
`timescale 1ns / 1ps

class fresnel_scoreboard;
   typedef struct {
      logic [16:0] refl;
      logic [16:0] trans;
      logic        tir;
   } fresnel_result_type;

   fresnel_result_type pending[$];
   int errors = 0;

   // Integer square root rounded to nearest.
   static function longint unsigned root_nearest(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      if (v > res) res = res + 1;
      return res;
   endfunction

   // Squared ratio a/b in Q20; a zero denominator counts as one.
   static function longint unsigned ratio_sq(longint unsigned a, longint unsigned b);
      longint unsigned b2;
      if (b == 0) return 64'd1 << 20;
      b2 = b * b;
      return ((a * a << 20) + (b2 >> 1)) / b2;
   endfunction

   // Note an accepted request beat and compute its expected result.
   function void note_request(logic [13:0] idx, logic [16:0] cosv);
      longint unsigned n, c, s2, m, w, p, ts, tp, r;
      fresnel_result_type e;
      n = idx;
      c = cosv;
      if (c > 65536) c = 65536;
      s2 = (64'd1 << 32) - c * c;
      m = n * n * 256;
      if (s2 > m) begin
         e.refl = 17'd65536;
         e.trans = 17'd0;
         e.tir = 1'b1;
      end else begin
         w = root_nearest(m - s2);
         p = (n * n * c + (64'd1 << 23)) >> 24;
         ts = ratio_sq((c > w) ? c - w : w - c, c + w);
         tp = ratio_sq((w > p) ? w - p : p - w, w + p);
         r = (ts + tp + 16) >> 5;
         if (r > 65536) r = 65536;
         e.refl = r[16:0];
         e.trans = 17'(65536 - r);
         e.tir = 1'b0;
      end
      pending = {pending, e};
   endfunction

   // Check one result beat against the oldest expectation.
   function void check_result(logic [16:0] refl, logic [16:0] trans, logic tir);
      fresnel_result_type e;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result refl=%0d trans=%0d tir=%0d",
                  $time, refl, trans, tir);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (refl !== e.refl) begin
         $display("%0t: reflectance expected %0d actual %0d", $time, e.refl, refl);
         errors++;
      end
      if (trans !== e.trans) begin
         $display("%0t: transmittance expected %0d actual %0d", $time, e.trans, trans);
         errors++;
      end
      if (tir !== e.tir) begin
         $display("%0t: total_reflection expected %0d actual %0d", $time, e.tir, tir);
         errors++;
      end
   endfunction
endclass

module fresnel_reflectance_unit_tb;
   import frp_pkg::*;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic [NW-1:0] req_rel_index = '0;
   logic [CW-1:0] req_cos_incidence = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic [CW-1:0] rsp_reflectance;
   logic [CW-1:0] rsp_transmittance;
   logic          rsp_total_reflection;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   fresnel_scoreboard board = new();

   fresnel_reflectance_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_rel_index(req_rel_index), .req_cos_incidence(req_cos_incidence),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_reflectance(rsp_reflectance), .rsp_transmittance(rsp_transmittance),
      .rsp_total_reflection(rsp_total_reflection)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Monitor both channels at the edge, before the drivers update.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_request(req_rel_index, req_cos_incidence);
         if (rsp_valid && rsp_ready)
            board.check_result(rsp_reflectance, rsp_transmittance, rsp_total_reflection);
      end
   end

   // Receiver stalls at random with the current phase's rate.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Send one request beat, with a random idle gap before it.
   task automatic send_beat(input logic [NW-1:0] idx, input logic [CW-1:0] cosv);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rel_index <= idx;
      req_cos_incidence <= cosv;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Random beat: mostly in range, sometimes near interesting points.
   task automatic send_random();
      logic [NW-1:0] idx;
      logic [CW-1:0] cosv;
      case ($urandom_range(5))
         0: idx = NW'($urandom_range(16383));
         1: idx = NW'($urandom_range(4100, 4092));
         default: idx = NW'($urandom_range(16383, 1024));
      endcase
      case ($urandom_range(5))
         0: cosv = CW'($urandom);
         1: cosv = CW'($urandom_range(65536, 65500));
         2: cosv = CW'($urandom_range(40));
         default: cosv = CW'($urandom_range(65536));
      endcase
      send_beat(idx, cosv);
   endtask

   initial begin
      int i;
      int ph;
      int wait_cycles;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed corners: index and cosine extremes, grazing and normal
      // incidence, n equal to one, total reflection, cosine above one, n zero.
      send_beat(14'd1024, 17'd0);
      send_beat(14'd16383, 17'd0);
      send_beat(14'd4096, 17'd0);
      send_beat(14'd4096, 17'd65536);
      send_beat(14'd4096, 17'd32768);
      send_beat(14'd1024, 17'd65536);
      send_beat(14'd16383, 17'd65536);
      send_beat(14'd2730, 17'd20000);
      send_beat(14'd2730, 17'd60000);
      send_beat(14'd6144, 17'd1);
      send_beat(14'd4096, 17'd131071);
      send_beat(14'd8000, 17'd100000);
      send_beat(14'd0, 17'd65536);
      send_beat(14'd0, 17'd1000);
      send_beat(14'd16383, 17'd131071);
      send_beat(14'd4095, 17'd0);
      send_beat(14'd4097, 17'd0);
      send_beat(14'd1024, 17'd63000);

      // Random beats across the idling phases.
      for (ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 57; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 57; end
            default: begin send_idle_pct = 18; recv_stall_pct = 18; end
         endcase
         for (i = 0; i < 410; i++) send_random();
      end
      req_valid <= 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;

      wait_cycles = 0;
      while (board.pending.size() != 0 && wait_cycles < 5000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (60) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("fresnel_reflectance_unit_tb passed");
      end else begin
         $display("fresnel_reflectance_unit_tb failed");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #2000000;
      $display("fresnel_reflectance_unit_tb failed");
      $finish;
   end
endmodule
